FILE: hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned DataW    = 32;
  localparam int unsigned OutCntW  = 5;

  typedef enum logic {
    OpEnq = 1'b0,
    OpDeq = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                     opcode;
    logic signed [DataW-1:0] data_in;
    logic signed [DataW-1:0] priority_in;
  } spq_in_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DataW-1:0] removed_data;
    logic                    head_valid;
    logic signed [DataW-1:0] head_data;
    logic signed [DataW-1:0] head_priority;
    logic [OutCntW-1:0]      entry_count;
  } spq_out_t;

  typedef struct packed {
    logic                    occ;
    logic signed [DataW-1:0] data;
    logic signed [DataW-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

FILE: hdl/spq_cell.sv
// One queue slot: compares against the incoming priority and shifts with its neighbors.
module spq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  spq_pkg::cell_ctl_t        ctl_i,
  input  logic signed [31:0]        new_data_i,
  input  logic signed [31:0]        new_prio_i,
  input  spq_pkg::entry_t           prev_i,
  input  logic                      prev_ins_i,
  input  spq_pkg::entry_t           next_i,
  output logic                      ins_o,
  output spq_pkg::entry_t           entry_o,
  output spq_pkg::entry_t           entry_d_o
);
  import spq_pkg::*;

  logic                    occ_q;
  logic signed [DataW-1:0] data_q;
  logic signed [DataW-1:0] prio_q;
  entry_t                  cur;
  entry_t                  nxt_d;

  assign cur = '{occ: occ_q, data: data_q, prio: prio_q};

  // Insert here when this slot is free or holds a strictly lower priority.
  assign ins_o = !occ_q || ($signed(prio_q) < $signed(new_prio_i));

  always_comb begin
    nxt_d = cur;
    if (ctl_i.enq) begin
      if (prev_ins_i) begin
        nxt_d = prev_i;
      end else if (ins_o) begin
        nxt_d = '{occ: 1'b1, data: new_data_i, prio: new_prio_i};
      end
    end else if (ctl_i.deq) begin
      nxt_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= nxt_d.occ;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= nxt_d.data;
    prio_q <= nxt_d.prio;
  end

  assign entry_o   = cur;
  assign entry_d_o = nxt_d;

endmodule

FILE: hdl/sorted_priority_queue.sv
// Top level of the sorted priority queue: a chain of slot cells plus the result register.
// Holds up to 16 entries sorted by descending signed priority, ties leaving in arrival
// order. Each transfer, enqueue or dequeue, is applied to every slot cell in parallel:
// each cell compares its priority with the incoming one and takes a value from itself,
// its neighbor or the input. One input transfer is taken per cycle; its result is presented
// in the output register the following cycle and input ready follows output space (output
// register empty or being drained). A full-queue enqueue or an empty-queue dequeue leaves
// the contents unchanged and reports it in status.
module sorted_priority_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  spq_pkg::spq_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output spq_pkg::spq_out_t out_o
);
  import spq_pkg::*;

  entry_t             entry_q [Capacity];
  entry_t             entry_d [Capacity];
  entry_t             prev_e  [Capacity];
  entry_t             next_e  [Capacity];
  logic [Capacity-1:0] ins;
  logic [Capacity-1:0] prev_ins;
  cell_ctl_t          ctl;
  logic               in_xfer;
  logic               is_deq;
  logic               full;
  logic               empty;
  logic [CountW-1:0]  count_q;
  logic [CountW-1:0]  count_d;
  logic               out_valid_q;
  spq_out_t           out_q;
  spq_out_t           out_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_deq     = (in_i.opcode == OpDeq);
  assign full       = entry_q[Capacity-1].occ;
  assign empty      = !entry_q[0].occ;
  assign ctl.enq    = in_xfer && !is_deq && !full;
  assign ctl.deq    = in_xfer && is_deq && !empty;

  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign prev_e[g]   = '0;
      assign prev_ins[g] = 1'b0;
    end else begin : g_mid
      assign prev_e[g]   = entry_q[g-1];
      assign prev_ins[g] = ins[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign next_e[g] = '0;
    end else begin : g_rest
      assign next_e[g] = entry_q[g+1];
    end

    spq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .new_data_i (in_i.data_in),
      .new_prio_i (in_i.priority_in),
      .prev_i     (prev_e[g]),
      .prev_ins_i (prev_ins[g]),
      .next_i     (next_e[g]),
      .ins_o      (ins[g]),
      .entry_o    (entry_q[g]),
      .entry_d_o  (entry_d[g])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ctl.enq) begin
      count_d = count_q + CountW'(1);
    end else if (ctl.deq) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_comb begin
    out_d               = '0;
    out_d.status        = StDone;
    if (is_deq && empty) begin
      out_d.status = StEmpty;
    end else if (!is_deq && full) begin
      out_d.status = StFull;
    end
    out_d.removed_data  = ctl.deq ? entry_q[0].data : '0;
    out_d.head_valid    = entry_d[0].occ;
    out_d.head_data     = entry_d[0].occ ? entry_d[0].data : '0;
    out_d.head_priority = entry_d[0].occ ? entry_d[0].prio : '0;
    out_d.entry_count   = OutCntW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

FILE: hdl/spq_checker.sv
// Port-level assertions for the sorted priority queue, bound to the top level.
module spq_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input spq_pkg::spq_out_t out_o
);
  import spq_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result changed before transfer");

  a_head_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.head_valid == (out_o.entry_count != '0)))
    else $error("head_valid disagrees with entry_count");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == StEmpty |->
      out_o.entry_count == '0 && out_o.removed_data == '0)
    else $error("empty status with entries held");

  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status == StFull |->
      out_o.entry_count == OutCntW'(Capacity) && out_o.removed_data == '0)
    else $error("full status without a full queue");

  a_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("transfer produced no result");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_o       (out_o)
);

FILE: sim/sorted_priority_queue_tb.sv
// Testbench for sorted_priority_queue: random enqueue/dequeue traffic checked against a shadow queue.
module sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int unsigned RandomOps  = 450;
  localparam int unsigned TailOps    = 60;
  localparam int unsigned StallStart = 150;
  localparam int unsigned StallLen   = 80;
  localparam int unsigned DrainWait  = 10;
  localparam int unsigned CycleLimit = 200000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  spq_in_t   in_i;
  logic      out_valid_o;
  logic      out_ready_i;
  spq_out_t  out_o;

  spq_in_t   pending_ops[$];
  spq_out_t  expected_results[$];

  logic signed [DataW-1:0] shadow_data [Capacity];
  logic signed [DataW-1:0] shadow_prio [Capacity];
  int        shadow_count;

  int        total_ops;
  int        accepted_cnt;
  int        result_cnt;
  int        mismatch_cnt;
  int        gap_left;
  int        stall_left;
  bit        long_stall_done;
  int        cycle_cnt;

  sorted_priority_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit in_tail();
    return pending_ops.size() < TailOps;
  endfunction

  function automatic spq_in_t make_op(input op_e op, input logic [DataW-1:0] d,
                                      input logic [DataW-1:0] p);
    spq_in_t item;
    item.opcode      = op;
    item.data_in     = d;
    item.priority_in = p;
    return item;
  endfunction

  // Sorted insert behind equal-or-higher priorities, dequeue from slot 0.
  task automatic predict_queue_op(input spq_in_t item);
    spq_out_t r;
    int       pos;
    r        = '0;
    r.status = StDone;
    if (item.opcode == OpEnq) begin
      if (shadow_count >= Capacity) begin
        r.status = StFull;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_prio[pos] >= item.priority_in) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_data[i] = shadow_data[i-1];
          shadow_prio[i] = shadow_prio[i-1];
        end
        shadow_data[pos] = item.data_in;
        shadow_prio[pos] = item.priority_in;
        shadow_count++;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = StEmpty;
      end else begin
        r.removed_data = shadow_data[0];
        for (int i = 0; i + 1 < shadow_count; i++) begin
          shadow_data[i] = shadow_data[i+1];
          shadow_prio[i] = shadow_prio[i+1];
        end
        shadow_count--;
      end
    end
    if (shadow_count > 0) begin
      r.head_valid    = 1'b1;
      r.head_data     = shadow_data[0];
      r.head_priority = shadow_prio[0];
    end
    r.entry_count = OutCntW'(shadow_count);
    expected_results.push_back(r);
    accepted_cnt++;
  endtask

  task automatic note_mismatch(input string what, input logic [DataW-1:0] exp_v,
                               input logic [DataW-1:0] act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("result %0d: %s expected %0h, got %0h", result_cnt, what, exp_v, act_v);
  endtask

  task automatic check_result(input spq_out_t got);
    spq_out_t exp_r;
    if (expected_results.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("result %0d: unexpected transfer %h", result_cnt, got);
    end else begin
      exp_r = expected_results.pop_front();
      if (got.status !== exp_r.status)
        note_mismatch("status", exp_r.status, got.status);
      if (got.removed_data !== exp_r.removed_data)
        note_mismatch("removed_data", exp_r.removed_data, got.removed_data);
      if (got.head_valid !== exp_r.head_valid)
        note_mismatch("head_valid", exp_r.head_valid, got.head_valid);
      if (got.head_data !== exp_r.head_data)
        note_mismatch("head_data", exp_r.head_data, got.head_data);
      if (got.head_priority !== exp_r.head_priority)
        note_mismatch("head_priority", exp_r.head_priority, got.head_priority);
      if (got.entry_count !== exp_r.entry_count)
        note_mismatch("entry_count", exp_r.entry_count, got.entry_count);
    end
    result_cnt++;
  endtask

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_queue_op(in_i);
      end
      if (in_valid_i && !in_ready_o) begin
        // hold until transfer
      end else if (gap_left > 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() > 0 && !in_tail() && $urandom_range(0, 5) == 0) begin
        gap_left   <= $urandom_range(1, 7) - 1;
        in_valid_i <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        in_i       <= pending_ops.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i     <= 1'b0;
      stall_left      <= 0;
      long_stall_done <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        check_result(out_o);
      end
      if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else if (!long_stall_done && accepted_cnt >= StallStart) begin
        long_stall_done <= 1'b1;
        stall_left      <= StallLen - 1;
        out_ready_i     <= 1'b0;
      end else if (!in_tail() && $urandom_range(0, 5) == 0) begin
        stall_left  <= $urandom_range(1, 7) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    logic [DataW-1:0] d;
    logic [DataW-1:0] p;
    int               enq_pct;
    int               pick;
    cycle_cnt    = 0;
    shadow_count = 0;
    accepted_cnt = 0;
    result_cnt   = 0;
    mismatch_cnt = 0;
    rst_ni       = 1'b0;

    // empty dequeue, fill with extremes and ties, enqueue on full, partial drain
    pending_ops.push_back(make_op(OpDeq, 32'h1234_5678, 32'h0));
    pending_ops.push_back(make_op(OpEnq, 32'h7fff_ffff, 32'h0000_0000));
    pending_ops.push_back(make_op(OpEnq, 32'h8000_0000, 32'h8000_0000));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_0000, 32'h7fff_ffff));
    pending_ops.push_back(make_op(OpEnq, 32'hffff_ffff, 32'hffff_ffff));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_0005, 32'h0000_0001));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_0006, 32'h0000_0005));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_0007, 32'h0000_0005));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_0008, 32'h0000_0005));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_0009, 32'h8000_0000));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_000a, 32'h7fff_ffff));
    pending_ops.push_back(make_op(OpEnq, 32'h5555_5555, 32'hffff_fffe));
    pending_ops.push_back(make_op(OpEnq, 32'haaaa_aaaa, 32'h8000_0001));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_000d, 32'h7fff_fffe));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_000e, 32'hffff_ffff));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_000f, 32'h0000_0000));
    pending_ops.push_back(make_op(OpEnq, 32'h0000_0010, 32'h0000_0005));
    pending_ops.push_back(make_op(OpEnq, 32'hdead_beef, 32'h7fff_ffff));
    repeat (5) pending_ops.push_back(make_op(OpDeq, 32'hffff_ffff, 32'hffff_ffff));

    // phases alternate fill-heavy and drain-heavy traffic
    for (int n = 0; n < RandomOps; n++) begin
      enq_pct = ((n / 40) % 2 == 0) ? 75 : 25;
      d       = $urandom;
      pick    = $urandom_range(0, 7);
      if (pick < 4)
        p = $urandom_range(0, 7) - 3;
      else if (pick == 4)
        p = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      else
        p = $urandom;
      if ($urandom_range(0, 99) < enq_pct)
        pending_ops.push_back(make_op(OpEnq, d, p));
      else
        pending_ops.push_back(make_op(OpDeq, d, p));
    end
    total_ops = pending_ops.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_ops) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue.sv
hdl/spq_checker.sv
sim/sorted_priority_queue_tb.sv
